// File: design/joystick_average_to_drive_top_macros.svh
// ----------------------------------------------------------------------------
// joystick_average_to_drive_top_macros.svh
// Assertion macros for the joystick average-to-drive block.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_AVERAGE_TO_DRIVE_TOP_MACROS_SVH
`define JOYSTICK_AVERAGE_TO_DRIVE_TOP_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define JATD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define JATD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/jatd_pkg.sv
// ----------------------------------------------------------------------------
// jatd_pkg
// Shared types and constants for the joystick average-to-drive block.
// ----------------------------------------------------------------------------
package jatd_pkg;

    localparam int AXES       = 2;
    localparam int SMP_W      = 8;
    localparam int SUM_W      = 12;
    localparam int DRIVE_W    = 8;
    localparam int WINDOW_DEF = 10;

    // sum / WINDOW as (sum * recip) >> DIV_SHIFT, exact for 12-bit sums
    localparam int DIV_SHIFT  = 20;
    localparam int RECIP_W    = 20;

    // x / 126 and x / 127 as (x * recip) >> MAP_SHIFT, exact for x < 2^14
    localparam int SCALE_W    = 14;
    localparam int MREC_W     = 15;
    localparam int MAP_SHIFT  = 21;
    localparam int MPROD_W    = SCALE_W + MREC_W;
    localparam int Q_W        = 7;

    localparam logic [MREC_W-1:0] RECIP_126 = 15'd16645;
    localparam logic [MREC_W-1:0] RECIP_127 = 15'd16514;

    localparam logic [SMP_W-1:0]  CENTRE    = 8'd127;
    localparam logic [SMP_W-1:0]  NEG_BASE  = 8'd128;
    localparam logic [SMP_W-1:0]  AVG_MAX   = 8'd255;
    localparam logic [Q_W-1:0]    FULL      = 7'd100;

    typedef logic [SMP_W-1:0]            t_sample;
    typedef logic [AXES-1:0][SMP_W-1:0]  t_cell_data;
    typedef logic [SUM_W-1:0]            t_sum;

endpackage

// File: design/jatd_cell.sv
// ----------------------------------------------------------------------------
// jatd_cell
// One window slot: holds a sample for each axis, shifts the addressed axis.
// ----------------------------------------------------------------------------
module jatd_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_shift,
    input  logic                  i_axis,
    input  jatd_pkg::t_cell_data  i_din,
    output jatd_pkg::t_cell_data  o_dout
);
    import jatd_pkg::*;

    t_cell_data r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data[i_axis] <= i_din[i_axis];
        end
    end

    assign o_dout = r_data;

endmodule

// File: design/jatd_map.sv
// ----------------------------------------------------------------------------
// jatd_map
// Pipeline: window sum to average, average to signed drive value.
// ----------------------------------------------------------------------------
module jatd_map #(
    parameter int WINDOW = jatd_pkg::WINDOW_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_vld,
    input  jatd_pkg::t_sum                     i_sum,
    output logic                               o_vld,
    output logic signed [jatd_pkg::DRIVE_W-1:0] o_drive
);
    import jatd_pkg::*;

    localparam int                 RECIP_INT = ((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_INT);
    localparam int                 DPROD_W   = SUM_W + RECIP_W;

    logic                     r_v2, r_v3, r_v4;
    t_sample                  r_avg;
    logic [SCALE_W-1:0]       r_x;
    logic                     r_neg, r_zero;
    logic [DRIVE_W-1:0]       r_drive;

    logic [DPROD_W-1:0]       w_dprod;
    logic [SUM_W-1:0]         w_quot;
    t_sample                  n_avg;
    logic [SCALE_W-1:0]       n_x;
    logic                     n_neg, n_zero;
    logic [MPROD_W-1:0]       w_mprod;
    logic [Q_W-1:0]           w_q;
    logic [DRIVE_W-1:0]       n_drive;

    // divide by the window
    always_comb begin
        w_dprod = DPROD_W'(i_sum) * DPROD_W'(RECIP);
        w_quot  = SUM_W'(w_dprod >> DIV_SHIFT);
        n_avg   = (w_quot > SUM_W'(AVG_MAX)) ? AVG_MAX : w_quot[SMP_W-1:0];
    end

    // split into forward / reverse half and scale by 100
    always_comb begin
        n_zero = (r_avg == CENTRE);
        n_neg  = (r_avg > CENTRE);
        if (r_avg < CENTRE) begin
            n_x = SCALE_W'(r_avg) * SCALE_W'(FULL);
        end else begin
            n_x = SCALE_W'(SMP_W'(r_avg - NEG_BASE)) * SCALE_W'(FULL);
        end
    end

    // divide by 126 / 127 and form the drive value
    always_comb begin
        w_mprod = MPROD_W'(r_x) * MPROD_W'(r_neg ? RECIP_127 : RECIP_126);
        w_q     = Q_W'(w_mprod >> MAP_SHIFT);
        if (r_zero) begin
            n_drive = '0;
        end else if (r_neg) begin
            n_drive = DRIVE_W'(0) - DRIVE_W'(w_q);
        end else begin
            n_drive = DRIVE_W'(FULL) - DRIVE_W'(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= i_vld;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_avg   <= n_avg;
            r_x     <= n_x;
            r_neg   <= n_neg;
            r_zero  <= n_zero;
            r_drive <= n_drive;
        end
    end

    assign o_vld   = r_v4;
    assign o_drive = $signed(r_drive);

endmodule

// File: design/joystick_average_to_drive_top.sv
// ----------------------------------------------------------------------------
// joystick_average_to_drive_top
// Two-axis moving-average filter with mapping to a signed drive value.
// A new sample transaction is taken every cycle while the output is not
// stalled; its drive value is registered in order through the sum update,
// the divide by the window, the scale and the divide by 126/127 in the
// mapping pipeline. The window is a shift chain of WINDOW cells, each cell
// holding one sample per axis; only the addressed axis shifts. Reset clears
// the window to zero, so the first WINDOW-1 outputs of an axis lean towards
// +100. A stalled output holds the whole pipeline and drops o_ready.
// ----------------------------------------------------------------------------
`include "joystick_average_to_drive_top_macros.svh"

module joystick_average_to_drive_top #(
    parameter int WINDOW = jatd_pkg::WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_axis,
    input  logic [jatd_pkg::SMP_W-1:0]          i_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [jatd_pkg::DRIVE_W-1:0] o_drive
);
    import jatd_pkg::*;

    localparam int SUM_MAX = WINDOW * 255;

    t_cell_data w_chain [0:WINDOW];
    t_sum       r_sum [AXES];
    t_sum       n_sum;
    t_sum       r_s1_sum;
    logic       r_s1_vld;
    logic       w_en;
    logic       w_acc;
    t_sample    w_oldest;

    assign w_en  = !o_valid || i_ready;
    assign o_ready = w_en;
    assign w_acc = i_valid && w_en;

    assign w_chain[0] = {AXES{i_sample}};

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        jatd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_acc),
            .i_axis  (i_axis),
            .i_din   (w_chain[g]),
            .o_dout  (w_chain[g+1])
        );
    end

    assign w_oldest = w_chain[WINDOW][i_axis];
    assign n_sum    = r_sum[i_axis] - SUM_W'(w_oldest) + SUM_W'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum[0] <= '0;
            r_sum[1] <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (w_acc) begin
                r_sum[i_axis] <= n_sum;
            end
            if (w_en) begin
                r_s1_vld <= w_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_sum <= n_sum;
        end
    end

    jatd_map #(
        .WINDOW (WINDOW)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s1_vld),
        .i_sum   (r_s1_sum),
        .o_vld   (o_valid),
        .o_drive (o_drive)
    );

    `JATD_ASSERT_NOW(a_drive_range, o_valid, ($signed(o_drive) <= 100) && ($signed(o_drive) >= -100), "drive out of range")
    `JATD_ASSERT_NOW(a_sum_bound, 1'b1, (r_sum[0] <= t_sum'(SUM_MAX)) && (r_sum[1] <= t_sum'(SUM_MAX)), "running sum exceeds window capacity")
    `JATD_ASSERT_NEXT(a_stage_fill, i_valid && o_ready, r_s1_vld, "accepted transaction lost in sum stage")

endmodule
